// ===== hw/rtl/mtps_pkg.sv =====
package mtps_pkg;

  localparam int COUNT_BITS_DEF = 10;
  localparam int NUM_TYPES_DEF  = 5;
  localparam int OUT_BITS       = 10;
  localparam int FIT_BITS       = 16;
  localparam int DRAW_BITS      = 16;
  localparam int IDX_BITS       = 3;

  localparam logic [FIT_BITS-1:0]  FIT_ONE  = 16'd16384;
  localparam logic [DRAW_BITS-1:0] HALF_Q16 = 16'd32768;

  // register indexes
  localparam logic [IDX_BITS-1:0] REG_FIT_A    = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_FIT_B    = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_FIT_DBL  = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_MUT_RATE = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_POP_SIZE = 3'd4;

  // outcome codes
  localparam logic [2:0] OC_RUNNING = 3'd0;
  localparam logic [2:0] OC_WILD    = 3'd1;
  localparam logic [2:0] OC_A_PURE  = 3'd2;
  localparam logic [2:0] OC_A_VIA   = 3'd3;
  localparam logic [2:0] OC_B_PURE  = 3'd4;
  localparam logic [2:0] OC_B_VIA   = 3'd5;

  // type indexes
  localparam logic [2:0] T_WILD = 3'd0;
  localparam logic [2:0] T_A    = 3'd1;
  localparam logic [2:0] T_B    = 3'd2;
  localparam logic [2:0] T_AB   = 3'd3;
  localparam logic [2:0] T_BA   = 3'd4;

  // sequencer to multiplier control
  typedef struct packed {
    logic load;
    logic [63:0] a;
    logic [15:0] b;
  } mul_req_t;

endpackage

// ===== hw/rtl/mtps_if.sv =====
interface mtps_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        start_with_b;
  logic [15:0] draw_pair;
  logic [15:0] draw_mutate;
  logic [15:0] draw_wild_target;
  logic [15:0] draw_fixation;
  modport source (output valid, kind, start_with_b, draw_pair, draw_mutate,
                  draw_wild_target, draw_fixation, input ready);
  modport sink (input valid, kind, start_with_b, draw_pair, draw_mutate,
                draw_wild_target, draw_fixation, output ready);
endinterface

interface mtps_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  count_wild;
  logic [9:0]  count_a;
  logic [9:0]  count_b;
  logic [9:0]  count_ab;
  logic [9:0]  count_ba;
  logic        run_done;
  logic [2:0]  outcome;
  modport source (output valid, count_wild, count_a, count_b, count_ab, count_ba,
                  run_done, outcome, input ready);
  modport sink (input valid, count_wild, count_a, count_b, count_ab, count_ba,
                run_done, outcome, output ready);
endinterface

interface mtps_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/moran_two_path_step_unit.sv =====
// Moran birth-death step unit over five types (wild, A, B, AB, BA). One item
// is taken at a time; ready stays low until its result is transferred. A start
// item, or a step with no active run, goes straight to the output state, which
// then raises valid for its result. A step item scans twenty ordered type pairs
// through one shared 64x16 multiplier: 20 weight products to form the total,
// then 2 products per pair to compare the draw against the running sum, the
// death, birth and fixation-check update phases, plus one fixation compare when
// only AB and BA remain; the scan stops early when the pair is found.
// Configuration is taken only between items, while the block is idle.
module moran_two_path_step_unit #(
  parameter int COUNT_BITS = mtps_pkg::COUNT_BITS_DEF,
  parameter int NUM_TYPES  = mtps_pkg::NUM_TYPES_DEF
) (
  input  logic     clk,
  input  logic     rst,
  mtps_in_if.sink  in_ch,
  mtps_out_if.source out_ch,
  mtps_cfg_if.sink cfg
);

  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
  localparam int TB = 3;
  localparam int CW = 2 * COUNT_BITS;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_TOTAL = 7'b0000010,
    S_MULT  = 7'b0000100,
    S_CMP   = 7'b0001000,
    S_APPLY = 7'b0010000,
    S_FIX   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;

  logic [15:0] fitness_a, fitness_b, fitness_double, mutation_rate;
  logic [9:0]  population_size;
  logic [COUNT_BITS-1:0] cnt [NUM_TYPES];
  logic run_finished;

  logic        kind_r;
  logic [15:0] d_pair, d_mut, d_wild, d_fix;

  logic [TB-1:0] pi, pj;
  logic [TB-1:0] rep, die;
  logic [1:0]    phase;
  logic [63:0]   total, sum, weight;
  logic          ovalid;
  logic [2:0]    oc_r;

  mtps_pkg::mul_req_t req;
  logic [79:0] prod;
  logic        mdone;

  mtps_mul u_mul (.clk(clk), .rst(rst), .req(req), .prod(prod), .done(mdone));

  // effective population size
  logic [COUNT_BITS-1:0] n_eff;
  always_comb begin
    if (population_size < 10'd2) n_eff = COUNT_BITS'(2);
    else if ({6'd0, population_size} > 16'(CMAX)) n_eff = CMAX;
    else n_eff = COUNT_BITS'(population_size);
  end

  function automatic logic [15:0] fit_of(input logic [TB-1:0] t,
                                         input logic [15:0] fa, fb, fd);
    case (t)
      mtps_pkg::T_WILD: fit_of = mtps_pkg::FIT_ONE;
      mtps_pkg::T_A:    fit_of = fa;
      mtps_pkg::T_B:    fit_of = fb;
      default:          fit_of = fd;
    endcase
  endfunction

  // outcome from counts
  logic [2:0] oc_now;
  logic [COUNT_BITS:0] s_a, s_b;
  always_comb begin
    s_a = {1'b0, cnt[1]} + {1'b0, cnt[3]};
    s_b = {1'b0, cnt[2]} + {1'b0, cnt[4]};
    if (cnt[0] == n_eff) oc_now = mtps_pkg::OC_WILD;
    else if (s_a == {1'b0, n_eff})
      oc_now = (cnt[1] == n_eff) ? mtps_pkg::OC_A_PURE : mtps_pkg::OC_A_VIA;
    else if (s_b == {1'b0, n_eff})
      oc_now = (cnt[2] == n_eff) ? mtps_pkg::OC_B_PURE : mtps_pkg::OC_B_VIA;
    else oc_now = mtps_pkg::OC_RUNNING;
  end

  // pair walk: j inner skipping i == j
  logic [TB-1:0] nj, ni;
  logic          last_pair;
  always_comb begin
    ni = pi;
    nj = pj + TB'(1);
    if (nj == pi) nj = nj + TB'(1);
    if (nj >= TB'(NUM_TYPES)) begin
      ni = pi + TB'(1);
      nj = (ni == '0) ? TB'(1) : '0;
    end
    last_pair = (ni >= TB'(NUM_TYPES));
  end

  assign in_ch.ready = (state == S_IDLE);
  assign cfg.ready   = (state == S_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fitness_a       <= 16'd16384;
      fitness_b       <= 16'd16384;
      fitness_double  <= 16'd16384;
      mutation_rate   <= 16'd0;
      population_size <= 10'd10;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        mtps_pkg::REG_FIT_A:    fitness_a       <= cfg.data;
        mtps_pkg::REG_FIT_B:    fitness_b       <= cfg.data;
        mtps_pkg::REG_FIT_DBL:  fitness_double  <= cfg.data;
        mtps_pkg::REG_MUT_RATE: mutation_rate   <= cfg.data;
        mtps_pkg::REG_POP_SIZE: population_size <= cfg.data[9:0];
        default: ;
      endcase
    end
  end

  logic [TB-1:0] btype;
  logic          mut_hit;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      run_finished <= 1'b1;
      ovalid       <= 1'b0;
      req.load     <= 1'b0;
      for (int t = 0; t < NUM_TYPES; t++) cnt[t] <= '0;
    end else begin
      req.load <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            kind_r <= in_ch.kind;
            d_pair <= in_ch.draw_pair;
            d_mut  <= in_ch.draw_mutate;
            d_wild <= in_ch.draw_wild_target;
            d_fix  <= in_ch.draw_fixation;
            if (!in_ch.kind) begin
              cnt[0] <= n_eff - COUNT_BITS'(1);
              cnt[1] <= in_ch.start_with_b ? '0 : COUNT_BITS'(1);
              cnt[2] <= in_ch.start_with_b ? COUNT_BITS'(1) : '0;
              cnt[3] <= '0;
              cnt[4] <= '0;
              run_finished <= 1'b0;
              state <= S_OUT;
            end else if (run_finished) begin
              state <= S_OUT;
            end else begin
              pi <= '0; pj <= TB'(1);
              total <= '0; sum <= '0; phase <= 2'd0;
              rep <= TB'(NUM_TYPES - 1); die <= TB'(NUM_TYPES - 2);
              req.load <= 1'b1;
              req.a <= 64'(CW'(cnt[0]) * CW'(cnt[1]));
              req.b <= mtps_pkg::FIT_ONE;
              state <= S_TOTAL;
            end
          end
        end
        // total weight: one product per pair
        S_TOTAL: begin
          if (mdone) begin
            total <= total + prod[63:0];
            if (last_pair) begin
              pi <= '0; pj <= TB'(1);
              req.load <= 1'b1;
              req.a <= 64'(CW'(cnt[0]) * CW'(cnt[1]));
              req.b <= mtps_pkg::FIT_ONE;
              state <= S_MULT;
            end else begin
              pi <= ni; pj <= nj;
              req.load <= 1'b1;
              req.a <= 64'(CW'(cnt[ni]) * CW'(cnt[nj]));
              req.b <= fit_of(ni, fitness_a, fitness_b, fitness_double);
            end
          end
        end
        // pair weight, then draw times total
        S_MULT: begin
          if (mdone) begin
            weight   <= prod[63:0];
            req.load <= 1'b1;
            req.a    <= total;
            req.b    <= d_pair;
            state    <= S_CMP;
          end
        end
        S_CMP: begin
          if (mdone) begin
            if (prod < {sum + weight, 16'd0}) begin
              rep <= pi; die <= pj;
              state <= S_APPLY;
            end else if (last_pair) begin
              state <= S_APPLY;
            end else begin
              sum <= sum + weight;
              pi <= ni; pj <= nj;
              req.load <= 1'b1;
              req.a <= 64'(CW'(cnt[ni]) * CW'(cnt[nj]));
              req.b <= fit_of(ni, fitness_a, fitness_b, fitness_double);
              state <= S_MULT;
            end
          end
        end
        // death and birth
        S_APPLY: begin
          if (phase == 2'd0) begin
            if (cnt[die] == '0) begin
              state <= S_OUT;
            end else begin
              cnt[die] <= cnt[die] - COUNT_BITS'(1);
              phase <= 2'd1;
            end
          end else if (phase == 2'd1) begin
            if (cnt[btype] != CMAX) cnt[btype] <= cnt[btype] + COUNT_BITS'(1);
            phase <= 2'd2;
          end else begin
            if (cnt[0] == '0 && cnt[1] == '0 && cnt[2] == '0 &&
                cnt[3] != '0 && cnt[4] != '0) begin
              req.load <= 1'b1;
              req.a <= 64'(n_eff);
              req.b <= d_fix;
              state <= S_FIX;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_FIX: begin
          if (mdone) begin
            if (prod < {48'd0, 16'(cnt[3]), 16'd0}) begin
              cnt[3] <= n_eff; cnt[4] <= '0;
            end else begin
              cnt[3] <= '0; cnt[4] <= n_eff;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!ovalid) begin
            if (kind_r && oc_now != mtps_pkg::OC_RUNNING) run_finished <= 1'b1;
            ovalid <= 1'b1;
            oc_r   <= oc_now;
          end else if (out_ch.ready) begin
            ovalid <= 1'b0;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // offspring type including mutation
  always_comb begin
    mut_hit = (d_mut < mutation_rate) && (rep < TB'(3));
    btype = rep;
    if (mut_hit) begin
      if (rep == mtps_pkg::T_A) btype = mtps_pkg::T_AB;
      else if (rep == mtps_pkg::T_B) btype = mtps_pkg::T_BA;
      else btype = (d_wild < mtps_pkg::HALF_Q16) ? mtps_pkg::T_B : mtps_pkg::T_A;
    end
  end

  // result outputs
  assign out_ch.valid      = ovalid;
  assign out_ch.count_wild = 10'(cnt[0]);
  assign out_ch.count_a    = 10'(cnt[1]);
  assign out_ch.count_b    = 10'(cnt[2]);
  assign out_ch.count_ab   = 10'(cnt[3]);
  assign out_ch.count_ba   = 10'(cnt[4]);
  assign out_ch.run_done   = run_finished;
  assign out_ch.outcome    = oc_r;

  // checks
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("ready while result pending");
  a_done_oc: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.outcome != mtps_pkg::OC_RUNNING) |-> out_ch.run_done)
    else $error("outcome without run_done");
  a_accept_leave: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> state != S_IDLE)
    else $error("item lost");

endmodule

// ===== hw/rtl/mtps_mul.sv =====
// shared multiplier: 64 x 16 product done as four 16 x 16 partial products
module mtps_mul (
  input  logic              clk,
  input  logic              rst,
  input  mtps_pkg::mul_req_t req,
  output logic [79:0]       prod,
  output logic              done
);

  logic [63:0] a;
  logic [15:0] b;
  logic [1:0]  step;
  logic        busy;
  logic [15:0] a_part;
  logic [31:0] pp;

  always_comb begin
    case (step)
      2'd0:    a_part = a[15:0];
      2'd1:    a_part = a[31:16];
      2'd2:    a_part = a[47:32];
      default: a_part = a[63:48];
    endcase
  end

  assign pp = a_part * b;

  // one partial product a cycle, accumulated at its weight
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (req.load) begin
        busy <= 1'b1;
        step <= 2'd0;
        a    <= req.a;
        b    <= req.b;
        prod <= '0;
      end else if (busy) begin
        prod <= prod + ({48'd0, pp} << {step, 4'd0});
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
